// File: rtl/fixed_model_arithmetic_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed model arithmetic encoder
// Clocked property checks used at the end of the encoder module.
// ----------------------------------------------------------------------------
`ifndef FIXED_MODEL_ARITHMETIC_ENCODER_UNIT_ASSERT_SVH
`define FIXED_MODEL_ARITHMETIC_ENCODER_UNIT_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define FMAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define FMAE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/fmae_pkg.sv
// ----------------------------------------------------------------------------
// fmae_pkg
// Types, constants and the letter model of the fixed model arithmetic encoder.
// ----------------------------------------------------------------------------
package fmae_pkg;

  // Field widths.
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned LOW_W    = 57;
  localparam int unsigned WIDTH_W  = 24;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned CUM_W    = 6;
  localparam int unsigned FREQ_W   = 3;
  localparam int unsigned PROD_W   = CUM_W + WIDTH_W;
  localparam int unsigned CMP_W    = LOW_W + 1;

  // Block and model constants.
  localparam logic [CNT_W-1:0]    BLOCK_LEN   = CNT_W'(10);
  localparam logic [LEN_W-1:0]    MAX_LEN     = LEN_W'(57);
  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(25);
  localparam logic [LETTER_W-1:0] FIRST_RARE  = LETTER_W'(6);
  localparam logic [CUM_W-1:0]    COMMON_SPAN = CUM_W'(30);
  localparam logic [FREQ_W-1:0]   FREQ_COMMON = FREQ_W'(5);
  localparam logic [FREQ_W-1:0]   FREQ_RARE   = FREQ_W'(1);

  // Input item.
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                block_end;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [LOW_W-1:0]   code_bits;
    logic [LEN_W-1:0]   code_length;
    logic [CNT_W-1:0]   block_letters;
    logic [LOW_W-1:0]   interval_low;
    logic [WIDTH_W-1:0] interval_width;
  } out_t;

  // Model entry of one letter.
  typedef struct packed {
    logic [CUM_W-1:0]  cum;
    logic [FREQ_W-1:0] freq;
  } model_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

  // Cumulative count and frequency of a letter; codes past z count as z.
  function automatic model_t letter_model(input logic [LETTER_W-1:0] letter);
    logic [LETTER_W-1:0] idx;
    model_t              m;
    idx = (letter > LAST_LETTER) ? LAST_LETTER : letter;
    if (idx < FIRST_RARE) begin
      m.cum  = CUM_W'(idx) * FREQ_COMMON;
      m.freq = FREQ_COMMON;
    end else begin
      m.cum  = COMMON_SPAN + CUM_W'(idx - FIRST_RARE);
      m.freq = FREQ_RARE;
    end
    return m;
  endfunction

endpackage

// File: rtl/fixed_model_arithmetic_encoder_unit.sv
// ----------------------------------------------------------------------------
// fixed_model_arithmetic_encoder_unit
// Block arithmetic encoder over the letters a to z with a fixed model.
// ----------------------------------------------------------------------------
// Usage:
// Letters arrive on the input channel (in_valid_i / in_ready_o / in_data_i),
// one transfer per letter. Each letter updates the exact interval of the
// block in the cycle of its transfer, so open blocks take one letter a cycle.
// A letter with block_end set, or the tenth letter, closes the block. The
// encoder then drops in_ready_o and runs its one shared 58-bit subtract and
// compare unit: L+1 steps at most to find the code length L, one step for
// the integer part and L steps of restoring division for the code word,
// then hands the result to the output register once that register is free.
// The result leaves on out_valid_o / out_ready_i / out_data_o. The output
// register lets the next block start while a result still waits; a stalled
// receiver holds the encoder only when a second result is ready.
// Reset clears the interval to [0, 1), the letter count to zero and the
// output register to empty; the encoder is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module fixed_model_arithmetic_encoder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fmae_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fmae_pkg::out_t out_data_o
);
  import fmae_pkg::*;

  `include "fixed_model_arithmetic_encoder_unit_assert.svh"

  // Sequencer and interval state.
  state_e             state_q, state_d;
  logic [LOW_W-1:0]   low_q, low_d;
  logic [WIDTH_W-1:0] width_q, width_d;
  logic [LOW_W-1:0]   scale_q, scale_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Length search and division registers.
  logic [CMP_W-1:0]   t_q, t_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   step_q, step_d;
  logic [LOW_W-1:0]   rem_q, rem_d;
  logic [CMP_W-1:0]   quo_q, quo_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  // Letter update terms.
  model_t             model;
  logic [PROD_W-1:0]  cum_prod;
  logic [CNT_W-1:0]   count_inc;
  logic               in_xfer;
  logic               out_free;

  // Shared subtract and compare unit.
  logic [CMP_W-1:0]   alu_a;
  logic [CMP_W:0]     alu_diff;
  logic               alu_ge;
  logic [CMP_W-1:0]   num;
  logic [CMP_W-1:0]   quo_fix;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Model lookup and the cumulative term of the low bound.
  assign model     = letter_model(in_data_i.letter);
  assign cum_prod  = PROD_W'(model.cum) * PROD_W'(width_q);
  assign count_inc = count_q + CNT_W'(1);

  // Upper bound numerator; it never exceeds the scale.
  assign num = CMP_W'(low_q) + CMP_W'(width_q);

  // Operand selection for the shared unit; the other operand is the scale.
  always_comb begin
    unique case (state_q)
      ST_LEN:  alu_a = t_q;
      ST_INIT: alu_a = num;
      ST_DIV:  alu_a = {rem_q, 1'b0};
      default: alu_a = t_q;
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {2'b00, scale_q};
  assign alu_ge   = !alu_diff[CMP_W];

  // An exact hit on the upper bound steps the code word down by one.
  assign quo_fix = ((rem_q == '0) && (quo_q != '0)) ? (quo_q - CMP_W'(1)) : quo_q;

  // Next state, interval update, division steps and result hand-off.
  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    width_d     = width_q;
    scale_d     = scale_q;
    count_d     = count_q;
    t_d         = t_q;
    len_d       = len_q;
    step_d      = step_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          low_d   = (low_q << 5) + (low_q << 4) + (low_q << 1) + LOW_W'(cum_prod);
          width_d = WIDTH_W'(width_q * WIDTH_W'(model.freq));
          scale_d = (scale_q << 5) + (scale_q << 4) + (scale_q << 1);
          count_d = count_inc;
          t_d     = CMP_W'(width_d);
          len_d   = '0;
          if (in_data_i.block_end || (count_inc >= BLOCK_LEN)) begin
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (alu_ge || (len_q == MAX_LEN)) begin
          state_d = ST_INIT;
        end else begin
          t_d   = {t_q[CMP_W-2:0], 1'b0};
          len_d = len_q + LEN_W'(1);
        end
      end
      ST_INIT: begin
        quo_d  = CMP_W'(alu_ge);
        rem_d  = alu_ge ? alu_diff[LOW_W-1:0] : num[LOW_W-1:0];
        step_d = len_q;
        state_d = (len_q == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        quo_d  = {quo_q[CMP_W-2:0], alu_ge};
        rem_d  = alu_ge ? alu_diff[LOW_W-1:0] : alu_a[LOW_W-1:0];
        step_d = step_q - LEN_W'(1);
        if (step_q == LEN_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.code_bits      = quo_fix[LOW_W-1:0];
          out_d.code_length    = len_q;
          out_d.block_letters  = count_q;
          out_d.interval_low   = low_q;
          out_d.interval_width = width_q;
          low_d   = '0;
          width_d = WIDTH_W'(1);
          scale_d = LOW_W'(1);
          count_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and interval accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      width_q     <= WIDTH_W'(1);
      scale_q     <= LOW_W'(1);
      count_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      width_q     <= width_d;
      scale_q     <= scale_d;
      count_q     <= count_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    out_q  <= out_d;
  end

  // The interval never leaves [0, 1) and never collapses.
  `FMAE_ASSERT(a_interval_inside, (state_q == ST_IDLE) |-> ((CMP_W'(low_q) + CMP_W'(width_q)) <= CMP_W'(scale_q)), "interval exceeds the unit range")
  `FMAE_ASSERT(a_width_nonzero, width_q != '0, "interval width is zero")
  // The division remainder stays below the divisor.
  `FMAE_ASSERT(a_rem_below_scale, (state_q == ST_DIV) |-> (rem_q < scale_q), "remainder not below scale")
  // A closing letter makes the encoder busy in the next cycle.
  `FMAE_ASSERT(a_close_busy, (in_xfer && in_data_i.block_end) |=> !in_ready_o, "closing letter did not start the code pass")
  // The code length never passes the field range.
  `FMAE_ASSERT_ALWAYS(a_len_range, len_q <= MAX_LEN, "code length out of range")

endmodule
